// File: sv/sequential_list_engine_macros.svh
// assertion shorthands for the sequential list engine
// included by modules that carry concurrent checks; needs clock and reset in scope
`ifndef SEQUENTIAL_LIST_ENGINE_MACROS_SVH
`define SEQUENTIAL_LIST_ENGINE_MACROS_SVH

// same-cycle implication, checks off while reset is high
`define SLE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checks off while reset is high
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/sle_pkg.sv
// shared types and constants for the sequential list engine
// no dependencies; used by sle_cell and sequential_list_engine
`default_nettype none

package sle_pkg;

   localparam int CAPACITY_DEF     = 64;
   localparam int PAYLOAD_BITS_DEF = 64;
   localparam int KEY_W            = 32;
   localparam int MODE_W           = 4;
   localparam int STATUS_W         = 3;

   typedef enum logic [MODE_W-1:0] {
      MODE_APPEND    = 4'd0,
      MODE_FRONT     = 4'd1,
      MODE_SORTED    = 4'd2,
      MODE_POP_FIRST = 4'd3,
      MODE_POP_LAST  = 4'd4,
      MODE_REM_SHIFT = 4'd5,
      MODE_REM_SWAP  = 4'd6,
      MODE_READ      = 4'd7,
      MODE_FIND      = 4'd8
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 3'd0,
      STAT_FULL     = 3'd1,
      STAT_EMPTY    = 3'd2,
      STAT_BADPOS   = 3'd3,
      STAT_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_EXEC
   } state_type;

   // what a cell loads on the commit edge
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_LOAD,
      OP_LEFT,
      OP_RIGHT
   } cell_op_type;

   typedef struct packed {
      logic hit;
      logic less;
   } cell_flags_type;

endpackage

`default_nettype wire

// File: sv/sle_cell.sv
// one storage cell of the list: a key and a payload word
// compares its key with the probe and loads from a neighbour or the fill bus; uses sle_pkg
`default_nettype none

module sle_cell
   import sle_pkg::*;
#(
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  wire                          clock,
   input  cell_op_type                  op,
   input  wire                          live,
   input  wire signed [KEY_W-1:0]       probe_key,
   input  wire signed [KEY_W-1:0]       left_key,
   input  wire        [PAYLOAD_BITS-1:0] left_payload,
   input  wire signed [KEY_W-1:0]       right_key,
   input  wire        [PAYLOAD_BITS-1:0] right_payload,
   input  wire signed [KEY_W-1:0]       fill_key,
   input  wire        [PAYLOAD_BITS-1:0] fill_payload,
   output cell_flags_type               flags,
   output logic signed [KEY_W-1:0]      key_out,
   output logic       [PAYLOAD_BITS-1:0] payload_out
);

   logic signed [KEY_W-1:0]       key_ff, key_in;
   logic        [PAYLOAD_BITS-1:0] payload_ff, payload_in;

   always_comb begin
      key_in     = key_ff;
      payload_in = payload_ff;
      unique case (op)
         OP_HOLD: begin
            key_in     = key_ff;
            payload_in = payload_ff;
         end
         OP_LOAD: begin
            key_in     = fill_key;
            payload_in = fill_payload;
         end
         OP_LEFT: begin
            key_in     = left_key;
            payload_in = left_payload;
         end
         OP_RIGHT: begin
            key_in     = right_key;
            payload_in = right_payload;
         end
         default: begin
            key_in     = key_ff;
            payload_in = payload_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

   assign flags.hit   = live && (key_ff == probe_key);
   assign flags.less  = live && (key_ff < probe_key);
   assign key_out     = key_ff;
   assign payload_out = payload_ff;

endmodule

`default_nettype wire

// File: sv/sequential_list_engine.sv
// channel | beat carries                               | accepted when
// req     | tuser mode; tdata key, payload, position   | req_tvalid && req_tready
// rsp     | tdata status, key, payload, count, flags   | rsp_tvalid && rsp_tready
//
// each command has a compare step and an execute step: all cells compare against the key in the first,
// the priority pick, shift or swap and the result happen in the second
// a new command is taken on the same edge that the previous one commits
// the result sits in an output register; a stalled rsp side holds the commit only
// synchronous active-high reset clears the count and the control, the cells need none
//
// top level of the sequential list engine: control, row of sle_cell, result register
// depends on sle_pkg, sle_cell and sequential_list_engine_macros.svh
`default_nettype none
`include "sequential_list_engine_macros.svh"

module sequential_list_engine
   import sle_pkg::*;
#(
   parameter int CAPACITY     = CAPACITY_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
   localparam int CNT_W       = $clog2(CAPACITY + 1),
   localparam int REQ_W       = KEY_W + PAYLOAD_BITS + CNT_W,
   localparam int REQ_TW      = ((REQ_W + 7) / 8) * 8,
   localparam int RSP_W       = STATUS_W + KEY_W + PAYLOAD_BITS + CNT_W + 2,
   localparam int RSP_TW      = ((RSP_W + 7) / 8) * 8
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_tvalid,
   output logic              req_tready,
   // key, payload, position, zero pad
   input  wire  [REQ_TW-1:0] req_tdata,
   // mode
   input  wire  [MODE_W-1:0] req_tuser,
   output logic              rsp_tvalid,
   input  wire               rsp_tready,
   // status, out_key, out_payload, count, full_res, empty_res, zero pad
   output logic [RSP_TW-1:0] rsp_tdata
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;

   mode_type                 cmd_mode_ff;
   logic signed [KEY_W-1:0]  cmd_key_ff;
   logic [PAYLOAD_BITS-1:0]  cmd_payload_ff;
   logic [CNT_W-1:0]         cmd_pos_ff;

   logic [CAPACITY-1:0]      hit_ff, ge_ff;
   logic signed [KEY_W-1:0]  sel_key_ff;
   logic [PAYLOAD_BITS-1:0]  sel_payload_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic signed [KEY_W-1:0]  rsp_key_ff, rsp_key_in;
   logic [PAYLOAD_BITS-1:0]  rsp_payload_ff, rsp_payload_in;
   logic [CNT_W-1:0]         rsp_count_ff;

   logic req_beat, out_free, commit;

   cell_op_type              cell_op     [CAPACITY];
   cell_flags_type           cell_flags  [CAPACITY];
   logic signed [KEY_W-1:0]  cell_key    [CAPACITY];
   logic [PAYLOAD_BITS-1:0]  cell_payload[CAPACITY];
   logic [CAPACITY-1:0]      cell_live;

   logic signed [KEY_W-1:0]  fill_key;
   logic [PAYLOAD_BITS-1:0]  fill_payload;

   logic [CNT_W-1:0] idx_hit, idx_ge, edit_pos, sel_addr;
   logic             ins_en, shift_en, swap_en;

   // ---------------------------------------------------------------- handshake
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = (state_ff == ST_EXEC) && out_free;
   assign req_tready = !reset && ((state_ff == ST_IDLE) || commit);
   assign req_beat   = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) state_in = ST_CMP;
         end
         ST_CMP: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (commit) state_in = req_beat ? ST_CMP : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         cmd_mode_ff    <= mode_type'(req_tuser);
         cmd_key_ff     <= req_tdata[KEY_W-1:0];
         cmd_payload_ff <= req_tdata[KEY_W +: PAYLOAD_BITS];
         cmd_pos_ff     <= req_tdata[KEY_W+PAYLOAD_BITS +: CNT_W];
      end
   end

   // ---------------------------------------------------------------- compare cycle
   assign sel_addr = (cmd_mode_ff == MODE_READ) ? (cmd_pos_ff - 1'b1) : (count_ff - 1'b1);

   always_ff @(posedge clock) begin
      if (state_ff == ST_CMP) begin
         for (int i = 0; i < CAPACITY; i++) begin
            hit_ff[i] <= cell_flags[i].hit;
            ge_ff[i]  <= cell_live[i] && !cell_flags[i].less;
         end
         // read position or last entry, whichever the command needs
         sel_key_ff     <= cell_key[sel_addr[IW-1:0]];
         sel_payload_ff <= cell_payload[sel_addr[IW-1:0]];
      end
   end

   // ---------------------------------------------------------------- execute cycle
   always_comb begin
      idx_hit = count_ff;
      idx_ge  = count_ff;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (hit_ff[i]) idx_hit = CNT_W'(i);
         if (ge_ff[i])  idx_ge  = CNT_W'(i);
      end
   end

   always_comb begin
      ins_en         = 1'b0;
      shift_en       = 1'b0;
      swap_en        = 1'b0;
      edit_pos       = '0;
      count_in       = count_ff;
      rsp_status_in  = STAT_OK;
      rsp_key_in     = '0;
      rsp_payload_in = '0;
      unique case (cmd_mode_ff)
         MODE_APPEND, MODE_FRONT, MODE_SORTED: begin
            if (count_ff == CAP_CNT) begin
               rsp_status_in = STAT_FULL;
            end else begin
               ins_en   = 1'b1;
               count_in = count_ff + 1'b1;
               if (cmd_mode_ff == MODE_APPEND)     edit_pos = count_ff;
               else if (cmd_mode_ff == MODE_FRONT) edit_pos = '0;
               else                                edit_pos = idx_ge;
            end
         end
         MODE_POP_FIRST, MODE_POP_LAST: begin
            if (count_ff == '0) begin
               rsp_status_in = STAT_EMPTY;
            end else begin
               shift_en = (cmd_mode_ff == MODE_POP_FIRST);
               count_in = count_ff - 1'b1;
            end
         end
         MODE_REM_SHIFT, MODE_REM_SWAP: begin
            if (count_ff == '0) begin
               rsp_status_in = STAT_EMPTY;
            end else if (idx_hit < count_ff) begin
               shift_en = (cmd_mode_ff == MODE_REM_SHIFT);
               swap_en  = (cmd_mode_ff == MODE_REM_SWAP);
               edit_pos = idx_hit;
               count_in = count_ff - 1'b1;
            end
         end
         MODE_READ: begin
            if (cmd_pos_ff == '0 || cmd_pos_ff > count_ff) begin
               rsp_status_in = STAT_BADPOS;
            end else begin
               rsp_key_in     = sel_key_ff;
               rsp_payload_in = sel_payload_ff;
            end
         end
         MODE_FIND: begin
            if (idx_hit >= count_ff) begin
               rsp_status_in = STAT_NOTFOUND;
            end else begin
               rsp_key_in     = cmd_key_ff;
               rsp_payload_in = cell_payload[idx_hit[IW-1:0]];
            end
         end
         default: begin
            rsp_status_in = STAT_OK;
         end
      endcase
      if (!commit) begin
         ins_en   = 1'b0;
         shift_en = 1'b0;
         swap_en  = 1'b0;
         count_in = count_ff;
      end
   end

   assign fill_key     = swap_en ? sel_key_ff : cmd_key_ff;
   assign fill_payload = swap_en ? sel_payload_ff : cmd_payload_ff;

   // ---------------------------------------------------------------- cell row
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      localparam int LI = (g > 0) ? g - 1 : g;
      localparam int RI = (g < CAPACITY - 1) ? g + 1 : g;

      assign cell_live[g] = CNT_W'(g) < count_ff;

      always_comb begin
         cell_op[g] = OP_HOLD;
         if (ins_en) begin
            if (CNT_W'(g) > edit_pos)       cell_op[g] = OP_LEFT;
            else if (CNT_W'(g) == edit_pos) cell_op[g] = OP_LOAD;
         end else if (shift_en) begin
            if (CNT_W'(g) >= edit_pos) cell_op[g] = OP_RIGHT;
         end else if (swap_en) begin
            if (CNT_W'(g) == edit_pos) cell_op[g] = OP_LOAD;
         end
      end

      sle_cell #(
         .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
         .clock         (clock),
         .op            (cell_op[g]),
         .live          (cell_live[g]),
         .probe_key     (cmd_key_ff),
         .left_key      (cell_key[LI]),
         .left_payload  (cell_payload[LI]),
         .right_key     (cell_key[RI]),
         .right_payload (cell_payload[RI]),
         .fill_key      (fill_key),
         .fill_payload  (fill_payload),
         .flags         (cell_flags[g]),
         .key_out       (cell_key[g]),
         .payload_out   (cell_payload[g])
      );
   end

   // ---------------------------------------------------------------- result register
   assign rsp_valid_in = commit || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_key_ff     <= rsp_key_in;
         rsp_payload_ff <= rsp_payload_in;
         rsp_count_ff   <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TW'({(rsp_count_ff == '0), (rsp_count_ff == CAP_CNT), rsp_count_ff,
                                rsp_payload_ff, rsp_key_ff, rsp_status_ff});

   // ---------------------------------------------------------------- checks
   `SLE_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CAP_CNT, "count above capacity")
   `SLE_ASSERT_NEXT(a_count_only_on_commit, !commit, $stable(count_ff),
      "count moved outside a commit")
   `SLE_ASSERT_NOW(a_full_status, rsp_valid_ff && rsp_status_ff == STAT_FULL,
      rsp_count_ff == CAP_CNT, "full status with room left")
   `SLE_ASSERT_NEXT(a_cmp_follows_beat, req_beat, state_ff == ST_CMP,
      "accepted beat not followed by compare")

endmodule

`default_nettype wire

// File: tb/sequential_list_engine_test.sv
// self-checking bench for sequential_list_engine: directed and random list commands
// with a behavioural list model in a small scoreboard; needs sle_pkg and the rtl

module sequential_list_engine_test;
   import sle_pkg::*;

   localparam int LIST_DEPTH   = CAPACITY_DEF;
   localparam int REQ_BITS     = 104;
   localparam int RSP_BITS     = 112;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 4'd9;
   localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 4'd15;
   localparam logic [31:0] KEY_MIN = 32'h8000_0000;
   localparam logic [31:0] KEY_MAX = 32'h7fff_ffff;
   localparam logic [31:0] KEY_POOL [8] = '{KEY_MIN, KEY_MAX, 32'hffff_ffff, 32'd0,
                                            32'd1, 32'd2, 32'h0000_0100, 32'hffff_ff00};

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [31:0]         key;
      logic [63:0]         payload;
      logic [6:0]          count;
      logic                full;
      logic                empty;
   } list_result_type;

   class list_scoreboard;
      logic [31:0]     keys [LIST_DEPTH];
      logic [63:0]     payloads [LIST_DEPTH];
      int              count = 0;
      list_result_type pending [$];
      int              errors = 0;
      int              checked = 0;
      int              full_results = 0;
      int              empty_results = 0;

      function void close_gap(int at);
         for (int j = at; j + 1 < count; j++) begin
            keys[j]     = keys[j + 1];
            payloads[j] = payloads[j + 1];
         end
         count--;
      endfunction

      // applies one accepted command to the list and queues the result it owes
      function void note_command(logic [MODE_W-1:0] mode, logic [31:0] key,
                                 logic [63:0] payload, logic [6:0] position);
         list_result_type r;
         int slot;
         int hit;
         r.status  = STAT_OK;
         r.key     = '0;
         r.payload = '0;
         hit = 0;
         while (hit < count && keys[hit] != key) hit++;
         case (mode)
            MODE_APPEND, MODE_FRONT, MODE_SORTED: begin
               if (count >= LIST_DEPTH) begin
                  r.status = STAT_FULL;
               end else begin
                  if (mode == MODE_APPEND) begin
                     slot = count;
                  end else begin
                     slot = 0;
                     if (mode == MODE_SORTED)
                        while (slot < count && $signed(keys[slot]) < $signed(key)) slot++;
                  end
                  for (int j = count; j > slot; j--) begin
                     keys[j]     = keys[j - 1];
                     payloads[j] = payloads[j - 1];
                  end
                  keys[slot]     = key;
                  payloads[slot] = payload;
                  count++;
               end
            end
            MODE_POP_FIRST, MODE_POP_LAST, MODE_REM_SHIFT, MODE_REM_SWAP: begin
               if (count == 0) begin
                  r.status = STAT_EMPTY;
               end else if (mode == MODE_POP_FIRST) begin
                  close_gap(0);
               end else if (mode == MODE_POP_LAST) begin
                  count--;
               end else if (hit < count) begin
                  if (mode == MODE_REM_SHIFT) begin
                     close_gap(hit);
                  end else begin
                     // last entry moves into the hole
                     count--;
                     keys[hit]     = keys[count];
                     payloads[hit] = payloads[count];
                  end
               end
            end
            MODE_READ: begin
               if (position == 0 || position > count) begin
                  r.status = STAT_BADPOS;
               end else begin
                  r.key     = keys[position - 1];
                  r.payload = payloads[position - 1];
               end
            end
            MODE_FIND: begin
               if (hit >= count) begin
                  r.status = STAT_NOTFOUND;
               end else begin
                  r.key     = keys[hit];
                  r.payload = payloads[hit];
               end
            end
            default: ;
         endcase
         r.count = 7'(count);
         r.full  = (count == LIST_DEPTH);
         r.empty = (count == 0);
         pending.push_back(r);
      endfunction

      function void compare_field(string field_name, logic [63:0] wanted, logic [63:0] got);
         if (wanted !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, field_name, wanted, got);
         end
      endfunction

      function void check_result(logic [RSP_BITS-1:0] beat);
         list_result_type want;
         checked++;
         if (beat[106]) full_results++;
         if (beat[107]) empty_results++;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: result beat %h with nothing outstanding", $time, beat);
            return;
         end
         want = pending.pop_front();
         compare_field("status", want.status, beat[2:0]);
         compare_field("out_key", want.key, beat[34:3]);
         compare_field("out_payload", want.payload, beat[98:35]);
         compare_field("count", want.count, beat[105:99]);
         compare_field("full_res", want.full, beat[106]);
         compare_field("empty_res", want.empty, beat[107]);
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   wire                 req_tready;
   // key, payload, position, zero pad
   logic [REQ_BITS-1:0] req_tdata = '0;
   // mode
   logic [MODE_W-1:0]   req_tuser = '0;
   wire                 rsp_tvalid;
   logic                rsp_tready = 1'b0;
   // status, out_key, out_payload, count, full_res, empty_res, zero pad
   wire [RSP_BITS-1:0]  rsp_tdata;

   list_scoreboard board = new;
   int             cycles = 0;
   int             commands_sent = 0;
   bit             sender_steady = 1'b0;
   bit             receiver_steady = 1'b0;
   int             round;

   sequential_list_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, board.pending.size());
         $display("** sequential_list_engine: FAILED **");
         $finish;
      end
   end

   // outputs are settled at the falling edge; a beat seen here is taken on the next rise
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
   end

   function automatic int idle_length(bit steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   initial begin
      int gap;
      forever begin
         @(posedge clock);
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         gap = idle_length(receiver_steady);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap - 1) @(posedge clock);
         end
      end
   end

   // called at a rising edge; returns at the edge that takes the beat
   task automatic send_command(logic [MODE_W-1:0] mode, logic [31:0] key,
                               logic [63:0] payload, logic [6:0] position);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {1'b0, position, payload, key};
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      board.note_command(mode, key, payload, position);
      commands_sent++;
   endtask

   task automatic sender_gap();
      int gap;
      gap = idle_length(sender_steady);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic issue(logic [MODE_W-1:0] mode, logic [31:0] key,
                        logic [63:0] payload, logic [6:0] position);
      send_command(mode, key, payload, position);
      sender_gap();
   endtask

   // with nothing outstanding the sender is already idle
   task automatic wait_until_drained();
      if (board.pending.size() != 0) begin
         req_tvalid <= 1'b0;
         while (board.pending.size() != 0) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_key();
      int r;
      r = $urandom_range(99);
      if (r < 45 && board.count > 0) return board.keys[$urandom_range(board.count - 1)];
      if (r < 80) return KEY_POOL[$urandom_range(7)];
      return $urandom();
   endfunction

   function automatic logic [63:0] pick_payload();
      int r;
      r = $urandom_range(19);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [6:0] pick_position();
      int r;
      r = $urandom_range(19);
      if (r == 0) return '0;
      if (r == 1) return 7'($urandom_range(127));
      return 7'($urandom_range(1, board.count + 1));
   endfunction

   function automatic logic [MODE_W-1:0] pick_mode(int insert_pct, int remove_pct);
      int r;
      r = $urandom_range(99);
      if (r < insert_pct) return MODE_W'($urandom_range(MODE_APPEND, MODE_SORTED));
      if (r < insert_pct + remove_pct)
         return MODE_W'($urandom_range(MODE_POP_FIRST, MODE_REM_SWAP));
      if (r < 97) return MODE_W'($urandom_range(MODE_READ, MODE_FIND));
      return MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
   endfunction

   // ignored modes do not count towards the phase length
   task automatic run_phase(int commands, int insert_pct, int remove_pct);
      logic [MODE_W-1:0] mode;
      int issued;
      issued = 0;
      sender_steady   = ($urandom_range(3) == 0);
      receiver_steady = ($urandom_range(3) == 0);
      while (issued < commands) begin
         mode = pick_mode(insert_pct, remove_pct);
         issue(mode, pick_key(), pick_payload(), pick_position());
         if (mode <= MODE_FIND) issued++;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // everything on an empty list
      issue(MODE_READ, 32'd0, '0, 7'd0);
      issue(MODE_READ, 32'd0, '0, 7'd1);
      issue(MODE_FIND, 32'd0, '0, 7'd0);
      issue(MODE_POP_FIRST, 32'd0, '0, 7'd0);
      issue(MODE_POP_LAST, 32'd0, '0, 7'd0);
      issue(MODE_REM_SHIFT, 32'd0, '0, 7'd0);
      issue(MODE_REM_SWAP, 32'd0, '0, 7'd0);
      // key extremes and ordered inserts on both sides of zero
      issue(MODE_APPEND, KEY_MIN, '1, 7'd0);
      issue(MODE_APPEND, KEY_MAX, '0, 7'd0);
      issue(MODE_FRONT, 32'd0, 64'h5555_5555_5555_5555, 7'd0);
      issue(MODE_SORTED, 32'hffff_ffff, 64'haaaa_aaaa_aaaa_aaaa, 7'd0);
      issue(MODE_SORTED, 32'd5, 64'h0123_4567_89ab_cdef, 7'd0);
      issue(MODE_READ, 32'd0, '0, 7'd1);
      issue(MODE_READ, 32'd0, '0, 7'd5);
      issue(MODE_READ, 32'd0, '0, 7'd6);
      issue(MODE_READ, 32'd0, '0, 7'd127);
      issue(MODE_FIND, KEY_MAX, '0, 7'd0);
      // duplicate key: find and removes take the first one
      issue(MODE_APPEND, 32'd0, 64'd1, 7'd0);
      issue(MODE_FIND, 32'd0, '0, 7'd0);
      issue(MODE_REM_SHIFT, 32'd12345, '0, 7'd0);
      issue(MODE_REM_SHIFT, 32'd0, '0, 7'd0);
      issue(MODE_REM_SWAP, KEY_MIN, '0, 7'd0);
      issue(MODE_UNUSED_HI, 32'hffff_ffff, '1, 7'd127);
      issue(MODE_UNUSED_LO, 32'd0, '0, 7'd0);
      issue(MODE_POP_FIRST, 32'd0, '0, 7'd0);
      issue(MODE_POP_LAST, 32'd0, '0, 7'd0);
      wait_until_drained();

      // grow to capacity, churn, then shrink to empty, three times over
      for (round = 0; round < 3; round++) begin
         run_phase(180, 65, 15);
         run_phase(90, 35, 35);
         wait_until_drained();
         run_phase(160, 15, 65);
      end

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d commands sent, %0d results checked over %0d cycles",
               commands_sent, board.checked, cycles);
      $display("%0d results at capacity, %0d with an empty list, %0d mismatches",
               board.full_results, board.empty_results, board.errors);
      if (board.errors == 0)
         $display("** sequential_list_engine: PASSED **");
      else
         $display("** sequential_list_engine: FAILED **");
      $finish;
   end

endmodule
